FILE: design/incremental_pid_controller_unit_macros.svh
// Assertion macros for the incremental PID controller unit
`ifndef INCREMENTAL_PID_CONTROLLER_UNIT_MACROS_SVH
`define INCREMENTAL_PID_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication
`define IPID_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IPID_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/ipid_pkg.sv
// Shared types and constants for the incremental PID controller unit
`default_nettype none

package ipid_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int SHIFT_W   = PROD_W - FRAC_BITS;
	localparam int SUM_W     = SHIFT_W + 2;
	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_COEF_NOW    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COEF_PREV   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_COEF_PREV2  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DRIVE_MIN   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DRIVE_MAX   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_LOOP_ENABLE = 3'd5;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	typedef struct packed {
		logic                     command;
		logic signed [DATA_W-1:0] error_sample;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] drive_value;
		logic                     disabled;
	} rsp_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] coef_now;
		logic signed [DATA_W-1:0] coef_prev;
		logic signed [DATA_W-1:0] coef_prev2;
		logic signed [DATA_W-1:0] drive_min;
		logic signed [DATA_W-1:0] drive_max;
		logic                     loop_enable;
	} cfg_t;

endpackage

`default_nettype wire

FILE: design/ipid_regs.sv
// APB configuration register file for the incremental PID controller unit
`default_nettype none

module ipid_regs
	import ipid_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;
	cfg_t                 cfg_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_COEF_NOW:    cfg_q.coef_now    <= pwdata;
				REG_COEF_PREV:   cfg_q.coef_prev   <= pwdata;
				REG_COEF_PREV2:  cfg_q.coef_prev2  <= pwdata;
				REG_DRIVE_MIN:   cfg_q.drive_min   <= pwdata;
				REG_DRIVE_MAX:   cfg_q.drive_max   <= pwdata;
				REG_LOOP_ENABLE: cfg_q.loop_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_COEF_NOW:    prdata = cfg_q.coef_now;
			REG_COEF_PREV:   prdata = cfg_q.coef_prev;
			REG_COEF_PREV2:  prdata = cfg_q.coef_prev2;
			REG_DRIVE_MIN:   prdata = cfg_q.drive_min;
			REG_DRIVE_MAX:   prdata = cfg_q.drive_max;
			REG_LOOP_ENABLE: prdata = {31'b0, cfg_q.loop_enable};
			default:         prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: design/ipid_core.sv
// Input register, PID update datapath, state and result register
`default_nettype none

module ipid_core
	import ipid_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	logic                      valid_s1;
	req_t                      req_s1;
	logic                      out_valid_q;
	rsp_t                      rsp_q;
	logic signed [DATA_W-1:0]  drive_accum_q;
	logic signed [DATA_W-1:0]  error_prev_q;
	logic signed [DATA_W-1:0]  error_prev2_q;

	logic                      advance;
	logic signed [PROD_W-1:0]  p_now, p_prev, p_prev2;
	logic signed [SHIFT_W-1:0] t_now, t_prev, t_prev2;
	logic signed [SUM_W-1:0]   sum;
	logic signed [DATA_W-1:0]  drive_next;

	assign advance   = !out_valid_q || rsp_ready;
	assign req_ready = !valid_s1 || advance;

	always_comb begin
		p_now   = PROD_W'(cfg.coef_now) * PROD_W'(req_s1.error_sample);
		p_prev  = PROD_W'(cfg.coef_prev) * PROD_W'(error_prev_q);
		p_prev2 = PROD_W'(cfg.coef_prev2) * PROD_W'(error_prev2_q);
		t_now   = p_now[PROD_W-1:FRAC_BITS];
		t_prev  = p_prev[PROD_W-1:FRAC_BITS];
		t_prev2 = p_prev2[PROD_W-1:FRAC_BITS];
		sum     = SUM_W'(drive_accum_q) + SUM_W'(t_now) + SUM_W'(t_prev)
			+ SUM_W'(t_prev2);
		if (sum > SUM_W'(cfg.drive_max)) begin
			drive_next = cfg.drive_max;
		end else if (sum < SUM_W'(cfg.drive_min)) begin
			drive_next = cfg.drive_min;
		end else begin
			drive_next = sum[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			drive_accum_q <= '0;
			error_prev_q  <= '0;
			error_prev2_q <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= valid_s1;
				if (valid_s1) begin
					if (req_s1.command == CMD_CLEAR) begin
						drive_accum_q <= '0;
						error_prev_q  <= '0;
						error_prev2_q <= '0;
					end else if (cfg.loop_enable) begin
						drive_accum_q <= drive_next;
						error_prev_q  <= req_s1.error_sample;
						error_prev2_q <= error_prev_q;
					end
				end
			end
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
		if (advance && valid_s1) begin
			rsp_q.disabled <= !cfg.loop_enable;
			if (req_s1.command == CMD_UPDATE && cfg.loop_enable) begin
				rsp_q.drive_value <= drive_next;
			end else begin
				rsp_q.drive_value <= '0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

FILE: design/incremental_pid_controller_unit.sv
// Top level of the incremental PID controller unit
// Velocity-form PID with output clamp: while loop_enable is set, each update adds
// coef_now*e[n], coef_prev*e[n-1] and coef_prev2*e[n-2] (each product shifted right by
// FRAC_BITS, truncating) to the kept drive, clamps it to [drive_min, drive_max] and shifts
// the error history; a clear command zeroes drive and history. One transfer is accepted per
// clock while the result register is free or being taken; its result passes through the
// input register, then the result register; the rate is set by the drive accumulator loop,
// three 32x32 multipliers, a 50-bit add and the clamp. Registers sit at byte addresses
// 0,4,..,20 of the APB port; the user must write them only while idle (no check in the block).
`default_nettype none
`include "incremental_pid_controller_unit_macros.svh"

module incremental_pid_controller_unit
	import ipid_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire req_t              req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output rsp_t                   rsp
);

	cfg_t cfg;

	ipid_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ipid_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	`IPID_ASSERT_IMPL(a_ready_when_empty, !rsp_valid, req_ready, "ready low with empty output")
	`IPID_ASSERT_IMPL(a_disabled_zero, rsp_valid && rsp.disabled, rsp.drive_value == '0, "disabled result not zero")
	`IPID_ASSERT_NEXT(a_coef_write, psel && penable && pwrite && paddr == '0, cfg.coef_now == $past(pwdata), "coef_now write lost")

endmodule

`default_nettype wire
